FILE: sv/least_loaded_core_dispatcher_defines.svh
// Assertion macros used by the dispatcher top level
`ifndef LEAST_LOADED_CORE_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_CORE_DISPATCHER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle
`define LLCD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle
`define LLCD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/llcd_pkg.sv
// Shared types and constants of the least-loaded core dispatcher
package llcd_pkg;
	localparam int TIME_W = 40;
	localparam int RANK_W = 12;
	localparam int SIZE_W = 20;
	localparam int SPEED_W = 16;
	localparam int CNT_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_HOST0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOST1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOST2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOST3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_XFER = 3'd4;

	// Sequencer states
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLR   = 9'b000000010,
		ST_SCAN  = 9'b000000100,
		ST_SCANW = 9'b000001000,
		ST_RD    = 9'b000010000,
		ST_RDW   = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_WB    = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;
endpackage

FILE: sv/llcd_div.sv
// Restoring bit-serial fixed-point divider, one quotient bit per cycle
module llcd_div #(
	parameter int FRAC = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [llcd_pkg::SIZE_W-1:0] dividend,
	input  logic [llcd_pkg::SPEED_W-1:0] divisor,
	output logic                        done,
	output logic [llcd_pkg::TIME_W-1:0] quotient
);
	import llcd_pkg::*;
	localparam int NW = SIZE_W + FRAC;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [SPEED_W:0] rem_q;
	logic [SPEED_W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [SPEED_W:0] trial;
	logic [SPEED_W:0] diff;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q[SPEED_W-1:0], num_q[NW-1]};
		diff = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {FRAC{1'b0}}};
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ~diff[SPEED_W]};
			rem_q <= diff[SPEED_W] ? trial : diff;
		end
	end

	// Zero divisor reads as all ones
	assign quotient = (dvs_q == '0) ? TIME_MAX : TIME_W'(num_q);
endmodule

FILE: sv/least_loaded_core_dispatcher.sv
// Least-loaded core dispatcher top level: sequencer, state memory, dividers
// The first block of a job runs the minimum scan (states ST_SCAN and ST_SCANW for each core)
// and then the serial dividers before out_valid; a continuation block skips the scan.
// One block at a time: the next word can be taken in the cycle after the result is accepted.
// Reset: a clearing pass zeroes every state memory entry; registers reset to 16,0,0,0 and 1.
module least_loaded_core_dispatcher #(
	parameter int HOSTS = 4,
	parameter int CORES_PER_HOST = 16,
	parameter int TIME_FRACTION_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [llcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic first_of_job,
	input  logic [19:0] data_size,
	input  logic [15:0] job_speed,
	input  logic [1:0] home_host,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] run_host,
	output logic [3:0] run_core,
	output logic [11:0] run_rank,
	output logic [39:0] start_time,
	output logic [39:0] end_time,
	output logic [39:0] move_time
);
	import llcd_pkg::*;
	`include "least_loaded_core_dispatcher_defines.svh"

	localparam int TOTAL = HOSTS * CORES_PER_HOST;
	localparam int FW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CPW = (CORES_PER_HOST > 1) ? $clog2(CORES_PER_HOST) : 1;
	localparam int HW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
	localparam int SW = $clog2(TOTAL + 1);

	state_t st_q;
	logic [CNT_W-1:0] cnt_q [4];
	logic [SPEED_W-1:0] xfer_q;
	logic [TIME_W+RANK_W-1:0] mem [TOTAL];
	logic [TIME_W+RANK_W-1:0] rd_q;
	logic mem_we;
	logic [FW-1:0] mem_wa, mem_ra;
	logic [TIME_W+RANK_W-1:0] mem_wd;
	logic [SW-1:0] idx_q;
	logic [FW-1:0] cur_q, best_q;
	logic found_q, job_open_q;
	logic [TIME_W-1:0] best_t_q;
	logic first_q;
	logic [SIZE_W-1:0] size_q;
	logic [SPEED_W-1:0] speed_q;
	logic [1:0] home_q;
	logic [TIME_W-1:0] start_q;
	logic [RANK_W-1:0] rank_q;
	logic dstart, ex_done, mv_done, ex_done_q, mv_done_q;
	logic [TIME_W-1:0] ex_quo, mv_quo, ex_q, mv_q;
	logic [HW-1:0] job_h_q, best_h_q, scan_h_q, pick_h;
	logic [CPW-1:0] job_c_q, best_c_q, scan_c_q, pick_c;
	logic [FW-1:0] pick_f;
	logic remote;
	logic [TIME_W:0] sum1, sum2;
	logic [TIME_W-1:0] s1sat;
	logic scan_active;
	logic [CNT_W-1:0] scan_lim;

	// Select the scanned winner, or flat core 0 when no core is active
	always_comb begin
		pick_f = found_q ? best_q : '0;
		pick_h = found_q ? best_h_q : '0;
		pick_c = found_q ? best_c_q : '0;
	end

	always_comb begin
		scan_lim = '0;
		if (32'(scan_h_q) < 4) scan_lim = cnt_q[2'(scan_h_q)];
		scan_active = ({27'b0, scan_lim} > 32'(scan_c_q)) && (32'(scan_h_q) < 4);
	end
	assign remote = ({30'b0, home_q} != 32'(job_h_q));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= CNT_W'(16);
			cnt_q[1] <= '0;
			cnt_q[2] <= '0;
			cnt_q[3] <= '0;
			xfer_q <= SPEED_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOST0: cnt_q[0] <= cfg_data[CNT_W-1:0];
				REG_HOST1: cnt_q[1] <= cfg_data[CNT_W-1:0];
				REG_HOST2: cnt_q[2] <= cfg_data[CNT_W-1:0];
				REG_HOST3: cnt_q[3] <= cfg_data[CNT_W-1:0];
				REG_XFER:  xfer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// State memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// Saturating end time
	always_comb begin
		sum1 = {1'b0, start_q} + {1'b0, ex_q};
		s1sat = sum1[TIME_W] ? TIME_MAX : sum1[TIME_W-1:0];
		sum2 = {1'b0, s1sat} + {1'b0, (remote ? mv_q : '0)};
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q;
		mem_wd = {end_time, run_rank};
		if (st_q == ST_SCAN) mem_ra = idx_q[FW-1:0];
		else if (st_q == ST_RD && first_q) mem_ra = pick_f;
		else mem_ra = cur_q;
		if (st_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_wa = idx_q[FW-1:0];
			mem_wd = '0;
		end else if (st_q == ST_WB) begin
			mem_we = 1'b1;
		end
	end

	assign in_ready = (st_q == ST_IDLE);
	assign dstart = (st_q == ST_RDW);

	llcd_div #(.FRAC(TIME_FRACTION_BITS)) u_ex (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(size_q),
		.divisor(speed_q), .done(ex_done), .quotient(ex_quo));
	llcd_div #(.FRAC(TIME_FRACTION_BITS)) u_mv (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(size_q),
		.divisor(xfer_q), .done(mv_done), .quotient(mv_quo));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			idx_q <= '0;
			cur_q <= '0;
			job_h_q <= '0;
			job_c_q <= '0;
			best_q <= '0;
			best_h_q <= '0;
			best_c_q <= '0;
			best_t_q <= '0;
			scan_h_q <= '0;
			scan_c_q <= '0;
			job_open_q <= 1'b0;
			out_valid <= 1'b0;
			found_q <= 1'b0;
			ex_done_q <= 1'b0;
			mv_done_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == SW'(TOTAL - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						scan_h_q <= '0;
						scan_c_q <= '0;
						found_q <= 1'b0;
						if (first_of_job || !job_open_q) begin
							st_q <= ST_SCAN;
							job_open_q <= 1'b1;
						end else begin
							st_q <= ST_RD;
						end
					end
				end
				ST_SCAN: st_q <= ST_SCANW;
				ST_SCANW: begin
					if (scan_active &&
						(!found_q || rd_q[TIME_W+RANK_W-1:RANK_W] < best_t_q)) begin
						found_q <= 1'b1;
						best_q <= idx_q[FW-1:0];
						best_h_q <= scan_h_q;
						best_c_q <= scan_c_q;
						best_t_q <= rd_q[TIME_W+RANK_W-1:RANK_W];
					end
					// Advance the host and core counters with the flat index
					if (scan_c_q == CPW'(CORES_PER_HOST - 1)) begin
						scan_c_q <= '0;
						scan_h_q <= scan_h_q + 1'b1;
					end else begin
						scan_c_q <= scan_c_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == SW'(TOTAL - 1)) st_q <= ST_RD;
					else st_q <= ST_SCAN;
				end
				ST_RD: begin
					if (first_q) begin
						cur_q <= pick_f;
						job_h_q <= pick_h;
						job_c_q <= pick_c;
					end
					st_q <= ST_RDW;
				end
				ST_RDW: begin
					ex_done_q <= 1'b0;
					mv_done_q <= 1'b0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (ex_done) ex_done_q <= 1'b1;
					if (mv_done) mv_done_q <= 1'b1;
					if ((ex_done || ex_done_q) && (mv_done || mv_done_q)) st_q <= ST_WB;
				end
				ST_WB: begin
					out_valid <= 1'b1;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the word, the read data, the quotients and the chosen host and core
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			first_q <= first_of_job || !job_open_q;
			size_q <= data_size;
			speed_q <= job_speed;
			home_q <= home_host;
		end
		if (st_q == ST_RDW) begin
			start_q <= rd_q[TIME_W+RANK_W-1:RANK_W];
			rank_q <= rd_q[RANK_W-1:0];
		end
		if (ex_done) ex_q <= ex_quo;
		if (mv_done) mv_q <= mv_quo;
		if (st_q == ST_DIV) begin
			run_host <= 2'(job_h_q);
			run_core <= 4'(job_c_q);
		end
	end

	assign run_rank = (rank_q == RANK_MAX) ? RANK_MAX : rank_q + 1'b1;
	assign start_time = start_q;
	assign move_time = remote ? mv_q : '0;
	assign end_time = sum2[TIME_W] ? TIME_MAX : sum2[TIME_W-1:0];

	`LLCD_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid, "ready while result pending")
	`LLCD_ASSERT_NEXT(a_wb_out, clk, arst_n, st_q == ST_WB, out_valid, "write-back without result")
	`LLCD_ASSERT_IMP(a_end_ge_start, clk, arst_n, out_valid, end_time >= start_time, "end before start")
endmodule
